// ===== hw/rtl/skac_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the skewed-associative cache tag store.
// No dependencies; used by every module of the block except skac_ram.
package skac_pkg;

  localparam int SETS_DEF        = 1024;
  localparam int WAYS_DEF        = 8;
  localparam int OFFSET_BITS_DEF = 6;
  localparam int ADDR_BITS_DEF   = 48;

  // Width of the line address field and of the stamps.
  localparam int LINE_BITS  = 48;
  localparam int STAMP_BITS = 32;
  localparam int PICK_BITS  = 3;

  // Ways share one of this many skew functions before an extra hash round.
  localparam int SKEW_FUNCS = 8;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_EVICT = 1'b1
  } cmd_t;

  localparam logic [1:0] CFG_INVALID_FIRST = 2'd0;
  localparam logic [1:0] CFG_USE_LRU       = 2'd1;

  // Handshake between the front queue and the back end.
  typedef struct packed {
    logic q_valid;
    logic clearing;
  } fb_status_t;

endpackage

// ===== hw/rtl/skac_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
module skac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/skac_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, computes the skewed set index of every way
// and holds the result in a two-entry queue. Depends on skac_pkg.
module skac_front #(
  parameter int SETS        = skac_pkg::SETS_DEF,
  parameter int WAYS        = skac_pkg::WAYS_DEF,
  parameter int OFFSET_BITS = skac_pkg::OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = skac_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [skac_pkg::LINE_BITS-1:0] in_addr,
  input  logic [skac_pkg::PICK_BITS-1:0] in_pick,
  input  logic                  clearing,
  input  logic                  q_pop,
  output logic                  q_valid,
  output logic                  q_cmd,
  output logic [((ADDR_BITS < skac_pkg::LINE_BITS) ? ADDR_BITS : skac_pkg::LINE_BITS)-1:0] q_addr,
  output logic [skac_pkg::PICK_BITS-1:0] q_pick,
  output logic [WAYS*$clog2(SETS)-1:0]   q_sets
);

  localparam int TW = (ADDR_BITS < skac_pkg::LINE_BITS) ? ADDR_BITS : skac_pkg::LINE_BITS;
  localparam int B  = $clog2(SETS + 1) - 1;
  localparam int SW = $clog2(SETS);
  localparam int XW = TW + OFFSET_BITS + 2 * B;
  localparam int EW = 1 + skac_pkg::PICK_BITS + TW + WAYS * SW;
  localparam logic [B-1:0] IDX_MASK = B'(SETS - 1);

  function automatic logic [B-1:0] mix_fwd(input logic [B-1:0] x);
    logic b;
    b = x[0] ^ x[B-1];
    return {b, x[B-1:1]};
  endfunction

  function automatic logic [B-1:0] mix_back(input logic [B-1:0] x);
    logic b;
    b = x[B-2] ^ x[B-1];
    return {x[B-2:0], b};
  endfunction

  logic [TW-1:0]        addr;
  logic [XW-1:0]        a_ext;
  logic [B-1:0]         lo;
  logic [B-1:0]         hi;
  logic [WAYS*SW-1:0]   sets;

  assign addr  = TW'(in_addr);
  assign a_ext = XW'(addr) >> OFFSET_BITS;
  assign lo    = a_ext[B-1:0];
  assign hi    = a_ext[2*B-1:B];

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [B-1:0] r;
    always_comb begin
      r = (((w & 4) != 0) ? mix_back(lo) : mix_fwd(lo))
        ^ (((w & 2) != 0) ? mix_back(hi) : mix_fwd(hi))
        ^ (((w & 1) != 0) ? lo : hi);
      for (int i = 0; i < w / skac_pkg::SKEW_FUNCS; i++) begin
        r = mix_fwd(r);
      end
    end
    assign sets[w*SW +: SW] = SW'(r & IDX_MASK);
  end

  // Two-entry queue.
  logic [EW-1:0] qmem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          push;

  assign in_ready = !clearing && (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign {q_cmd, q_pick, q_addr, q_sets} = qmem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp] <= {in_cmd, in_pick, addr, sets};
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (q_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hw/rtl/skac_back.sv =====
`timescale 1ns / 1ps
// Back end: per-way tag RAM banks, hit detection, victim choice, write-back
// and the result register. Depends on skac_pkg and skac_ram.
module skac_back #(
  parameter int SETS        = skac_pkg::SETS_DEF,
  parameter int WAYS        = skac_pkg::WAYS_DEF,
  parameter int ADDR_BITS   = skac_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  invalid_first,
  input  logic                  use_lru,
  input  skac_pkg::fb_status_t  fb,
  output logic                  q_pop,
  input  logic                  q_cmd,
  input  logic [((ADDR_BITS < skac_pkg::LINE_BITS) ? ADDR_BITS : skac_pkg::LINE_BITS)-1:0] q_addr,
  input  logic [skac_pkg::PICK_BITS-1:0] q_pick,
  input  logic [WAYS*$clog2(SETS)-1:0]   q_sets,
  output logic                  clearing,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic                  out_ev_valid,
  output logic [skac_pkg::LINE_BITS-1:0] out_ev_addr
);

  localparam int TW  = (ADDR_BITS < skac_pkg::LINE_BITS) ? ADDR_BITS : skac_pkg::LINE_BITS;
  localparam int SW  = $clog2(SETS);
  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int STB = skac_pkg::STAMP_BITS;
  localparam int RW  = STB + 1 + TW;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FILL  = 5'b10000
  } state_t;

  state_t           state;
  logic [SW-1:0]    clr_cnt;
  logic [STB-1:0]   clock_r;
  logic             cmd_r;
  logic [TW-1:0]    addr_r;
  logic [skac_pkg::PICK_BITS-1:0] pick_r;
  logic [WAYS*SW-1:0] sets_r;
  logic [STB-1:0]   ages [WAYS];
  logic [STB-1:0]   oldest;
  logic [WW-1:0]    scan_idx;
  logic [WW-1:0]    victim;
  logic             found;
  logic             report;

  logic [RW-1:0]    rdata [WAYS];
  logic [WAYS-1:0]  we;
  logic [SW-1:0]    waddr [WAYS];
  logic [RW-1:0]    wdata [WAYS];
  logic [WAYS-1:0]  hit_vec;
  logic [WAYS-1:0]  inv_vec;
  logic             hit_any;
  logic [WW-1:0]    hit_idx;
  logic             inv_any;
  logic [WW-1:0]    inv_idx;
  logic [WW-1:0]    pick_way;
  logic             res_set;

  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && fb.q_valid && !out_valid;

  for (genvar w = 0; w < WAYS; w++) begin : g_bank
    skac_ram #(.WIDTH(RW), .DEPTH(SETS)) u_ram (
      .clk   (clk),
      .we    (we[w]),
      .waddr (waddr[w]),
      .wdata (wdata[w]),
      .re    (q_pop),
      .raddr (q_sets[w*SW +: SW]),
      .rdata (rdata[w])
    );
    assign hit_vec[w] = rdata[w][TW] && (rdata[w][TW-1:0] == addr_r);
    assign inv_vec[w] = !rdata[w][TW];
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    inv_any = 1'b0;
    inv_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_idx = WW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (inv_vec[w]) begin
        inv_any = 1'b1;
        inv_idx = WW'(w);
      end
    end
  end

  // Random way reduced modulo the way count.
  always_comb begin
    logic [skac_pkg::PICK_BITS-1:0] v;
    v = pick_r;
    for (int i = 0; i < (1 << skac_pkg::PICK_BITS); i++) begin
      if (32'(v) >= 32'(WAYS)) begin
        v = v - skac_pkg::PICK_BITS'(WAYS);
      end
    end
    pick_way = WW'(v);
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      we[w]    = 1'b0;
      waddr[w] = sets_r[w*SW +: SW];
      wdata[w] = {clock_r, 1'b1, addr_r};
      unique case (state)
        S_CLEAR: begin
          we[w]    = 1'b1;
          waddr[w] = clr_cnt;
          wdata[w] = {STB'(w * SETS) + STB'(clr_cnt), 1'b0, TW'(0)};
        end
        S_LOOK: begin
          if (hit_any && hit_idx == WW'(w)) begin
            we[w] = 1'b1;
            if (cmd_r == skac_pkg::CMD_EVICT) begin
              wdata[w] = {rdata[w][RW-1:TW+1], 1'b0, rdata[w][TW-1:0]};
            end
          end
        end
        S_FILL: begin
          we[w] = (victim == WW'(w));
        end
        default: ;
      endcase
    end
  end

  assign res_set = ((state == S_LOOK) && (hit_any || cmd_r == skac_pkg::CMD_EVICT))
                || (state == S_FILL);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r  <= q_cmd;
      addr_r <= q_addr;
      pick_r <= q_pick;
      sets_r <= q_sets;
    end
    if (state == S_LOOK) begin
      for (int w = 0; w < WAYS; w++) begin
        ages[w] <= clock_r - rdata[w][RW-1:TW+1];
      end
    end
    if (res_set) begin
      if (state == S_LOOK && cmd_r == skac_pkg::CMD_EVICT) begin
        out_hit      <= hit_any;
        out_ev_valid <= hit_any;
        out_ev_addr  <= hit_any ? skac_pkg::LINE_BITS'(addr_r) : '0;
      end else if (state == S_FILL && report && rdata[victim][TW]) begin
        out_hit      <= 1'b0;
        out_ev_valid <= 1'b1;
        out_ev_addr  <= skac_pkg::LINE_BITS'(rdata[victim][TW-1:0]);
      end else begin
        out_hit      <= (state == S_LOOK);
        out_ev_valid <= 1'b0;
        out_ev_addr  <= '0;
      end
    end
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      clock_r   <= STB'(SETS * WAYS);
      out_valid <= 1'b0;
      scan_idx  <= '0;
      victim    <= '0;
      oldest    <= '0;
      found     <= 1'b0;
      report    <= 1'b0;
    end else begin
      if (res_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SW'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (hit_any || cmd_r == skac_pkg::CMD_EVICT) begin
            if (hit_any && cmd_r == skac_pkg::CMD_READ) begin
              clock_r <= clock_r + 1'b1;
            end
            state <= S_IDLE;
          end else if (inv_any && invalid_first) begin
            victim <= inv_idx;
            report <= 1'b0;
            state  <= S_FILL;
          end else if (use_lru) begin
            victim   <= inv_idx;
            found    <= inv_any;
            oldest   <= '0;
            scan_idx <= '0;
            report   <= 1'b1;
            state    <= S_SCAN;
          end else begin
            victim <= pick_way;
            report <= 1'b1;
            state  <= S_FILL;
          end
        end
        S_SCAN: begin
          if (ages[scan_idx] > oldest) begin
            oldest <= ages[scan_idx];
            victim <= scan_idx;
            found  <= 1'b1;
          end else if (scan_idx == WW'(WAYS - 1) && !found) begin
            victim <= '0;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == WW'(WAYS - 1)) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          clock_r <= clock_r + 1'b1;
          state   <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) && !out_valid)
    else $error("item taken while a result is pending");
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    res_set |-> !out_valid)
    else $error("result overwrites an undelivered result");
  a_fill_tick: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |=> clock_r == $past(clock_r) + 1'b1)
    else $error("fill did not advance the stamp clock");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> we == '0)
    else $error("tag bank written while idle");
`endif

endmodule

// ===== hw/rtl/skewed_assoc_cache_tags.sv =====
`timescale 1ns / 1ps
// Top level of the skewed-associative cache tag store.
// Depends on skac_pkg, skac_front, skac_back and skac_ram.
//
// Each input beat is a read-with-fill or an evict of one line address; every
// way looks the line up in its own set, derived from the address by a
// per-way skew hash, so the WAYS banks of SETS entries are read in parallel.
// After reset the block sweeps all banks once, one set per cycle in every
// way at the same time; no input beat is accepted during that sweep, but
// configuration writes are. The front end hashes the address and queues up
// to two items, so until the queue is full it keeps accepting while the back
// end works or a result waits on the output. In the back end a hit or an
// evict passes the bank read, then the compare, which writes back on a hit;
// a read miss adds a fill state to write the victim, and a read miss under
// LRU replacement first scans the ways, comparing their ages one per cycle,
// unless invalid-first filling is on and a way is invalid. The back end
// starts a new item only once the previous result has left the output
// register. Configuration must be written only while the block is idle.
module skewed_assoc_cache_tags #(
  parameter int SETS        = skac_pkg::SETS_DEF,
  parameter int WAYS        = skac_pkg::WAYS_DEF,
  parameter int OFFSET_BITS = skac_pkg::OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = skac_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input beats.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // line_addr[47:0], victim_pick[50:48], zero pad
  input  logic        s_tuser,   // cmd
  // Result beats.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // hit[0], evicted_valid[1], evicted_addr[49:2], zero pad
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data
);

  localparam int TW = (ADDR_BITS < skac_pkg::LINE_BITS) ? ADDR_BITS : skac_pkg::LINE_BITS;
  localparam int SW = $clog2(SETS);

  logic invalid_first;
  logic use_lru;

  // Register writes are always accepted; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_first <= 1'b0;
      use_lru       <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == skac_pkg::CFG_INVALID_FIRST) begin
        invalid_first <= cfg_data;
      end
      if (cfg_index == skac_pkg::CFG_USE_LRU) begin
        use_lru <= cfg_data;
      end
    end
  end

  logic                         clearing;
  logic                         q_pop;
  logic                         q_valid;
  logic                         q_cmd;
  logic [TW-1:0]                q_addr;
  logic [skac_pkg::PICK_BITS-1:0] q_pick;
  logic [WAYS*SW-1:0]           q_sets;
  skac_pkg::fb_status_t         fb;
  logic                         out_hit;
  logic                         out_ev_valid;
  logic [skac_pkg::LINE_BITS-1:0] out_ev_addr;

  assign fb = '{q_valid: q_valid, clearing: clearing};

  skac_front #(
    .SETS(SETS), .WAYS(WAYS), .OFFSET_BITS(OFFSET_BITS), .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_addr  (s_tdata[47:0]),
    .in_pick  (s_tdata[50:48]),
    .clearing (fb.clearing),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_addr   (q_addr),
    .q_pick   (q_pick),
    .q_sets   (q_sets)
  );

  skac_back #(
    .SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .invalid_first (invalid_first),
    .use_lru       (use_lru),
    .fb            (fb),
    .q_pop         (q_pop),
    .q_cmd         (q_cmd),
    .q_addr        (q_addr),
    .q_pick        (q_pick),
    .q_sets        (q_sets),
    .clearing      (clearing),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_hit       (out_hit),
    .out_ev_valid  (out_ev_valid),
    .out_ev_addr   (out_ev_addr)
  );

  assign m_tdata = {6'd0, out_ev_addr, out_ev_valid, out_hit};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for skewed_assoc_cache_tags: streams read and evict beats,
// predicts every result with a behavioral tag store and compares them beat by beat.
// Depends on skac_pkg and the RTL of the block.
module tb;

  localparam int NSETS  = 1024;
  localparam int NWAYS  = 8;
  localparam int OFFS   = 6;
  localparam int IBITS  = 10;
  localparam int LIMIT  = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    skac_pkg::cmd_t cmd;
    logic [47:0]    addr;
    logic [2:0]     pick;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        ev_valid;
    logic [47:0] ev_addr;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic        cfg_data = 1'b0;

  skewed_assoc_cache_tags i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral copy of the tag store.
  logic [47:0] tags   [NWAYS*NSETS];
  logic        valids [NWAYS*NSETS];
  logic [31:0] stamps [NWAYS*NSETS];
  logic [31:0] stamp_now;
  logic        fill_invalid_first;
  logic        lru_mode;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int accepted  = 0;
  int results   = 0;
  int hits      = 0;
  int evictions = 0;
  int cycles    = 0;

  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt  = 0;

  function automatic logic [IBITS-1:0] rot_fwd(logic [IBITS-1:0] x);
    return {x[0] ^ x[IBITS-1], x[IBITS-1:1]};
  endfunction

  function automatic logic [IBITS-1:0] rot_back(logic [IBITS-1:0] x);
    return {x[IBITS-2:0], x[IBITS-2] ^ x[IBITS-1]};
  endfunction

  // Set index used by one way for a line address.
  function automatic int skew_set(logic [47:0] addr, int way);
    logic [47:0]      a;
    logic [IBITS-1:0] lo, hi, p, q, r;
    a  = addr >> OFFS;
    lo = a[IBITS-1:0];
    hi = a[2*IBITS-1:IBITS];
    p  = (way & 4) ? rot_back(lo) : rot_fwd(lo);
    q  = (way & 2) ? rot_back(hi) : rot_fwd(hi);
    r  = p ^ q ^ ((way & 1) ? lo : hi);
    for (int i = 0; i < way / skac_pkg::SKEW_FUNCS; i++) r = rot_fwd(r);
    return int'(r);
  endfunction

  function automatic resp_t lookup_and_fill(req_t rq);
    resp_t       rs;
    int          ent [NWAYS];
    int          inval, victim;
    logic [31:0] oldest, age;
    rs = '0;
    inval = -1;
    for (int w = 0; w < NWAYS; w++) ent[w] = w * NSETS + skew_set(rq.addr, w);
    if (rq.cmd == skac_pkg::CMD_EVICT) begin
      for (int w = 0; w < NWAYS; w++) begin
        if (valids[ent[w]] && tags[ent[w]] == rq.addr) begin
          valids[ent[w]] = 1'b0;
          rs = '{1'b1, 1'b1, rq.addr};
          return rs;
        end
      end
      return rs;
    end
    for (int w = 0; w < NWAYS; w++) begin
      if (valids[ent[w]] && tags[ent[w]] == rq.addr) begin
        stamps[ent[w]] = stamp_now;
        stamp_now++;
        rs.hit = 1'b1;
        return rs;
      end
      if (!valids[ent[w]]) inval = w;
    end
    victim = inval;
    if (!(inval >= 0 && fill_invalid_first)) begin
      if (lru_mode) begin
        oldest = 0;
        for (int w = 0; w < NWAYS; w++) begin
          age = stamp_now - stamps[ent[w]];
          if (age > oldest) begin
            oldest = age;
            victim = w;
          end
        end
        if (victim < 0) victim = 0;
      end else begin
        victim = int'(rq.pick) % NWAYS;
      end
      if (valids[ent[victim]]) begin
        rs.ev_valid = 1'b1;
        rs.ev_addr  = tags[ent[victim]];
      end
    end
    tags[ent[victim]]   = rq.addr;
    valids[ent[victim]] = 1'b1;
    stamps[ent[victim]] = stamp_now;
    stamp_now++;
    return rs;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", results, what, got, want);
    errors++;
  endtask

  // Driver: offers the oldest pending beat; prediction is made at acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_resps.insert(expected_resps.size(),
                              lookup_and_fill(pending_reqs.pop_front()));
        accepted++;
      end
      if ((!s_tvalid || s_tready) && pending_reqs.size() > 0 &&
          (s_tvalid && s_tready ? pending_reqs.size() > 0 : 1'b1)) begin
        if ($urandom_range(99) >= idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {5'b0, pending_reqs[0].pick, pending_reqs[0].addr};
          s_tuser  <= pending_reqs[0].cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end else if (s_tvalid && s_tready) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver stall, timed in cycles on its own.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Monitor: receiver readiness and checking of result beats.
  always @(posedge clk) begin
    resp_t got, want;
    cycles++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.hit      = m_tdata[0];
        got.ev_valid = m_tdata[1];
        got.ev_addr  = m_tdata[49:2];
        if (m_tdata[55:50] != '0) report_mismatch("pad", {42'b0, m_tdata[55:50]}, '0);
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata[47:0], '0);
        end else begin
          want = expected_resps.pop_front();
          if (got.hit != want.hit) report_mismatch("hit", 48'(got.hit), 48'(want.hit));
          if (got.ev_valid != want.ev_valid)
            report_mismatch("evicted_valid", 48'(got.ev_valid), 48'(want.ev_valid));
          if (got.ev_addr != want.ev_addr)
            report_mismatch("evicted_addr", got.ev_addr, want.ev_addr);
          hits      += want.hit && !want.ev_valid;
          evictions += want.ev_valid;
        end
        results++;
      end
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == skac_pkg::CFG_INVALID_FIRST) fill_invalid_first = val;
    else if (idx == skac_pkg::CFG_USE_LRU) lru_mode = val;
  endtask

  // Waits until every expectation is met, then lets the block settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_addr();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Addresses drawn from a small pool so sets fill and lines get reused.
  function automatic logic [47:0] pool_addr(int pool);
    int k;
    k = $urandom_range(pool - 1);
    return {16'h5a00 + 16'(k[3:0]), 16'h0, 4'h0, 6'(k >> 4), 6'(k)};
  endfunction

  task automatic queue_random(int n, int pool);
    req_t rq;
    for (int i = 0; i < n; i++) begin
      rq.cmd  = ($urandom_range(99) < 25) ? skac_pkg::CMD_EVICT : skac_pkg::CMD_READ;
      rq.addr = ($urandom_range(99) < 85) ? pool_addr(pool) : rand_addr();
      rq.pick = 3'($urandom());
      pending_reqs.insert(pending_reqs.size(), rq);
    end
  endtask

  initial begin
    req_t rq;
    for (int e = 0; e < NWAYS * NSETS; e++) begin
      tags[e]   = '0;
      valids[e] = 1'b0;
      stamps[e] = 32'(e);
    end
    stamp_now          = 32'(NWAYS * NSETS);
    fill_invalid_first = 1'b0;
    lru_mode           = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: address extremes, hit, miss fill, evict hit and miss.
    write_reg(skac_pkg::CFG_INVALID_FIRST, 1'b1);
    write_reg(skac_pkg::CFG_USE_LRU, 1'b1);
    write_reg(2'd3, 1'b1);            // unused index must be ignored
    rq = '{skac_pkg::CMD_READ, 48'h0, 3'd0};
    pending_reqs.insert(pending_reqs.size(), rq);
    rq = '{skac_pkg::CMD_READ, 48'h0, 3'd0};
    pending_reqs.insert(pending_reqs.size(), rq);
    rq = '{skac_pkg::CMD_READ, 48'hFFFF_FFFF_FFFF, 3'd7};
    pending_reqs.insert(pending_reqs.size(), rq);
    rq = '{skac_pkg::CMD_EVICT, 48'hFFFF_FFFF_FFFF, 3'd7};
    pending_reqs.insert(pending_reqs.size(), rq);
    rq = '{skac_pkg::CMD_EVICT, 48'hFFFF_FFFF_FFFF, 3'd0};
    pending_reqs.insert(pending_reqs.size(), rq);
    rq = '{skac_pkg::CMD_EVICT, 48'h1234_5678_9ABC, 3'd5};
    pending_reqs.insert(pending_reqs.size(), rq);
    // Ten lines with the same low slices overflow the ways of one set group.
    for (int i = 0; i < 10; i++) begin
      rq = '{skac_pkg::CMD_READ, {16'(i), 32'h0000_0040}, 3'(i)};
      pending_reqs.insert(pending_reqs.size(), rq);
    end
    drain();

    // Random phases with several register settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(skac_pkg::CFG_INVALID_FIRST, ph[0]);
      write_reg(skac_pkg::CFG_USE_LRU, ph[1]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      if (ph == 2) hold_req = 1'b1;   // long receiver stall: input must back up
      queue_random(220, (ph < 4) ? 64 : 1024);
      drain();
    end

    $display("Covered %0d beats over 8 register/idle phases: %0d hits, %0d lines removed.",
             accepted, hits, evictions);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/skac_pkg.sv
hw/rtl/skac_ram.sv
hw/rtl/skac_front.sv
hw/rtl/skac_back.sv
hw/rtl/skewed_assoc_cache_tags.sv
tb/tb.sv
